// ===== rtl/core/sample_report_line_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample report line formatter.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_REPORT_LINE_FORMATTER_ASSERT_SVH
`define SAMPLE_REPORT_LINE_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define SRLF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srlf assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define SRLF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srlf assertion failed");

`endif

// ===== rtl/core/srlf_pkg.sv =====
// ----------------------------------------------------------------------------
// srlf_pkg
// Shared types, character codes and the byte-to-BCD conversion of the
// sample report line formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package srlf_pkg;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam int NUM_SAMPLES = 6;
	localparam int CNT_DIGITS  = 5;
	localparam int SMP_DIGITS  = 3;
	localparam int LINE_LEN    = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [3:0] digit_t;

	// One decoded report: counter digits and sample digits, most significant
	// digit at the highest index. Sample one sits at index zero.
	typedef struct packed {
		digit_t [CNT_DIGITS-1:0]                   cnt;
		digit_t [NUM_SAMPLES-1:0][SMP_DIGITS-1:0]  smp;
	} report_t;

	// Shift-and-add-three conversion of one byte into three BCD digits.
	function automatic logic [11:0] bin8_to_bcd(input logic [7:0] v);
		logic [11:0] b;
		b = '0;
		for (int i = 7; i >= 0; i--) begin
			for (int d = 0; d < 3; d++) begin
				if (b[d*4 +: 4] >= 4'd5)
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
			end
			b = {b[10:0], v[i]};
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srlf_front.sv =====
// ----------------------------------------------------------------------------
// srlf_front
// Accepts report ticks, advances the tick counter in binary and in BCD, and
// converts the six samples to decimal digits for the line queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srlf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        sample_1,
	input  wire logic [7:0]        sample_2,
	input  wire logic [7:0]        sample_3,
	input  wire logic [7:0]        sample_4,
	input  wire logic [7:0]        sample_5,
	input  wire logic [7:0]        sample_6,
	input  wire logic              q_full,
	output logic                   q_push,
	output srlf_pkg::report_t      q_data
);

	logic [15:0]                                      tick_q;
	srlf_pkg::digit_t [srlf_pkg::CNT_DIGITS-1:0]      bcd_q;
	srlf_pkg::digit_t [srlf_pkg::CNT_DIGITS-1:0]      bcd_next;
	logic                                             carry;
	logic [srlf_pkg::NUM_SAMPLES-1:0][7:0]            smp;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign smp      = {sample_6, sample_5, sample_4, sample_3, sample_2, sample_1};

	// Decimal increment of the counter copy; the binary counter decides the wrap.
	always_comb begin
		carry    = 1'b1;
		bcd_next = bcd_q;
		for (int d = 0; d < srlf_pkg::CNT_DIGITS; d++) begin
			if (carry) begin
				if (bcd_q[d] == 4'd9) begin
					bcd_next[d] = 4'd0;
				end else begin
					bcd_next[d] = bcd_q[d] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		if (tick_q == 16'hFFFF)
			bcd_next = '0;
	end

	always_comb begin
		q_data.cnt = bcd_next;
		for (int s = 0; s < srlf_pkg::NUM_SAMPLES; s++)
			q_data.smp[s] = srlf_pkg::bin8_to_bcd(smp[s]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			bcd_q  <= '0;
		end else if (q_push) begin
			tick_q <= tick_q + 16'd1;
			bcd_q  <= bcd_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/srlf_queue.sv =====
// ----------------------------------------------------------------------------
// srlf_queue
// Short register queue of decoded reports between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srlf_queue #(
	parameter int DEPTH = srlf_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire srlf_pkg::report_t  push_data,
	input  wire logic               pop,
	output logic                    full,
	output logic                    empty,
	output srlf_pkg::report_t       head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	srlf_pkg::report_t  mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/srlf_back.sv =====
// ----------------------------------------------------------------------------
// srlf_back
// Walks the 32 character positions of the head report and sends one
// character per beat through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srlf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire srlf_pkg::report_t  q_head,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_char,
	output logic                    line_end
);

	localparam logic [4:0] LAST_POS = 5'(srlf_pkg::LINE_LEN - 1);

	logic [4:0]        pos_q;
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              line_end_q;
	logic              fire;
	logic [7:0]        chr;
	logic [4:0]        cnt_off;
	logic [4:0]        smp_off;
	logic [2:0]        smp_sel;
	logic [1:0]        dig_sel;

	assign fire  = !q_empty && (!out_valid_q || out_ready);
	assign q_pop = fire && (pos_q == LAST_POS);

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign line_end  = line_end_q;

	// Line layout: CR, LF, five counter digits, TAB, then six groups of three
	// digits and a TAB each.
	always_comb begin
		cnt_off = 5'd6 - pos_q;
		smp_off = pos_q - 5'd8;
		smp_sel = smp_off[4:2];
		dig_sel = smp_off[1:0];
		if (pos_q == 5'd0)
			chr = srlf_pkg::CH_CR;
		else if (pos_q == 5'd1)
			chr = srlf_pkg::CH_LF;
		else if (pos_q <= 5'd6)
			chr = srlf_pkg::CH_ZERO + {4'h0, q_head.cnt[cnt_off[2:0]]};
		else if (pos_q == 5'd7 || dig_sel == 2'd3)
			chr = srlf_pkg::CH_TAB;
		else
			chr = srlf_pkg::CH_ZERO + {4'h0, q_head.smp[smp_sel][2'd2 - dig_sel]};
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char_q <= chr;
			line_end_q <= (pos_q == LAST_POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pos_q       <= pos_q + 5'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sample_report_line_formatter.sv =====
// ----------------------------------------------------------------------------
// sample_report_line_formatter
// Turns one report tick of six byte samples into a 32-character ASCII line.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat carries sample_1..sample_6.
// Each accepted beat bumps a 16-bit tick counter (wrapping to zero) and
// queues one line: CR, LF, the counter as five digits, TAB, then each
// sample as three digits followed by TAB.
// Output channel (out_valid/out_ready): one character per beat; line_end
// marks the final TAB of each line.
// When the back end is free, the first character of a line passes the
// queue and then the output register before it is valid.
// Throughput: one character per cycle while out_ready stays high; the
// character emitter is the limit. The input side takes a new report while
// fewer than QDEPTH lines, the one being sent included, are queued, so up
// to QDEPTH input beats can arrive back to back.
// A stalled receiver holds the current character; the emitter and then the
// input side stop in turn, and nothing is lost.
// Reset clears the counter, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_report_line_formatter #(
	parameter int QDEPTH = srlf_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  sample_1,
	input  wire logic [7:0]  sample_2,
	input  wire logic [7:0]  sample_3,
	input  wire logic [7:0]  sample_4,
	input  wire logic [7:0]  sample_5,
	input  wire logic [7:0]  sample_6,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_char,
	output logic             line_end
);

	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	srlf_pkg::report_t  q_wdata;
	srlf_pkg::report_t  q_head;

	srlf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_1 (sample_1),
		.sample_2 (sample_2),
		.sample_3 (sample_3),
		.sample_4 (sample_4),
		.sample_5 (sample_5),
		.sample_6 (sample_6),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	srlf_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	srlf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.line_end  (line_end)
	);

endmodule

`default_nettype wire

// ===== rtl/core/srlf_checker.sv =====
// ----------------------------------------------------------------------------
// srlf_checker
// Port-level checks of the sample report line formatter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_report_line_formatter_assert.svh"

module srlf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_char,
	input wire logic        line_end
);

	// A stalled beat stays offered and unchanged.
	`SRLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(line_end))

	// The end-of-line mark only ever rides on a TAB.
	`SRLF_ASSERT_IMPL(a_end_is_tab, out_valid && line_end, out_char == srlf_pkg::CH_TAB)

	// Back pressure at the input only appears while lines are being sent.
	`SRLF_ASSERT_IMPL(a_full_has_output, !in_ready, out_valid)

	// A completed line is followed by the start of the next one, or by idle.
	`SRLF_ASSERT_NEXT(a_after_end, out_valid && out_ready && line_end, !out_valid || out_char == srlf_pkg::CH_CR)

endmodule

bind sample_report_line_formatter srlf_checker u_srlf_checker (.*);

`default_nettype wire
